@@ rtl/assert_macros.svh @@
// Assertion macros used by the controller of the segment sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LMMS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define LMMS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LMMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lmms_pkg.sv @@
// Shared types for the line midpoint merge sorter.
package lmms_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS,
        S_RUN,
        S_RIDX,
        S_RKEY,
        S_CMP,
        S_OIDX,
        S_OPAY,
        S_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic idx_rd;
        logic key_rd;
        logic merge_wr;
        logic take_b;
        logic src_bank;
        logic pay_rd;
    } lmms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic less_ba;
    } lmms_stat_t;

    localparam int COLOR_BITS = 32;

endpackage

@@ rtl/lmms_dp.sv @@
// Datapath: segment, key and index memories plus the key comparator.
module lmms_dp
    import lmms_pkg::*;
#(
    parameter int COORD_BITS   = 16,
    parameter int AW           = 6,
    parameter int PW           = 160
) (
    input  logic            aclk,
    input  lmms_cmd_t       cmd,
    output lmms_stat_t      stat,
    input  logic [PW-1:0]   in_payload,
    input  logic [AW-1:0]   load_addr,
    input  logic [AW-1:0]   rd_a_addr,
    input  logic [AW-1:0]   rd_b_addr,
    input  logic [AW-1:0]   wr_addr,
    output logic [PW-1:0]   out_payload
);

    localparam int KH = COORD_BITS + 1;
    localparam int KW = 2 * KH;
    localparam int EO = 3 * COORD_BITS + COLOR_BITS;

    logic [PW-1:0] pay_mem [2**AW];
    logic [KW-1:0] key_mem [2**AW];
    logic [AW-1:0] idx_mem [2**(AW+1)];

    logic [AW-1:0] idx_a_reg, idx_b_reg;
    logic [KW-1:0] key_a_reg, key_b_reg;
    logic [PW-1:0] pay_reg;

    logic signed [KH-1:0] sum_x, sum_y;
    logic [KW-1:0]        key_in;
    logic                 idx_we;
    logic [AW:0]          idx_waddr;
    logic [AW-1:0]        idx_wdata;
    logic signed [KH-1:0] xa, ya, xb, yb;

    // Midpoint key: endpoint sums, x in the upper half.
    always_comb begin
        sum_x  = KH'($signed(in_payload[0 +: COORD_BITS]))
               + KH'($signed(in_payload[EO +: COORD_BITS]));
        sum_y  = KH'($signed(in_payload[COORD_BITS +: COORD_BITS]))
               + KH'($signed(in_payload[EO + COORD_BITS +: COORD_BITS]));
        key_in = {sum_x, sum_y};
    end

    // The index memory has one write port, shared by loading and merging.
    always_comb begin
        idx_we    = cmd.load_wr || cmd.merge_wr;
        idx_waddr = cmd.load_wr ? {1'b0, load_addr} : {~cmd.src_bank, wr_addr};
        idx_wdata = cmd.load_wr ? load_addr : (cmd.take_b ? idx_b_reg : idx_a_reg);
    end

    // Memory writes.
    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            pay_mem[load_addr] <= in_payload;
            key_mem[load_addr] <= key_in;
        end
        if (idx_we) begin
            idx_mem[idx_waddr] <= idx_wdata;
        end
    end

    // Registered memory reads.
    always_ff @(posedge aclk) begin
        if (cmd.idx_rd) begin
            idx_a_reg <= idx_mem[{cmd.src_bank, rd_a_addr}];
            idx_b_reg <= idx_mem[{cmd.src_bank, rd_b_addr}];
        end
        if (cmd.key_rd) begin
            key_a_reg <= key_mem[idx_a_reg];
            key_b_reg <= key_mem[idx_b_reg];
        end
        if (cmd.pay_rd) begin
            pay_reg <= pay_mem[idx_a_reg];
        end
    end

    // Strict order: b goes before a on smaller x, or equal x and smaller y.
    always_comb begin
        xa = $signed(key_a_reg[KW-1 -: KH]);
        ya = $signed(key_a_reg[KH-1:0]);
        xb = $signed(key_b_reg[KW-1 -: KH]);
        yb = $signed(key_b_reg[KH-1:0]);
        stat.less_ba = (xb < xa) || ((xb == xa) && (yb < ya));
    end

    assign out_payload = pay_reg;

endmodule

@@ rtl/lmms_ctrl.sv @@
// Controller: load counting, merge pass sequencing and output sequencing.
`include "assert_macros.svh"
module lmms_ctrl
    import lmms_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int AW           = 6,
    parameter int CW           = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_last,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_last,
    output logic          m_user,
    output lmms_cmd_t     cmd,
    input  lmms_stat_t    stat,
    output logic [AW-1:0] load_addr,
    output logic [AW-1:0] rd_a_addr,
    output logic [AW-1:0] rd_b_addr,
    output logic [AW-1:0] wr_addr
);

    localparam int W = CW + 2;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic          src_reg, src_next;
    logic [W-1:0]  width_reg, width_next;
    logic [W-1:0]  lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next, k_reg, k_next;
    logic [W-1:0]  n_ext, lo_w, lo_2w;
    logic          take_b;

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            src_reg   <= 1'b0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            src_reg   <= src_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            k_reg     <= k_next;
        end
    end

    // Run bounds, memory addresses and the merge decision.
    always_comb begin
        n_ext     = W'(count_reg);
        lo_w      = lo_reg + width_reg;
        lo_2w     = lo_reg + (width_reg << 1);
        load_addr = count_reg[AW-1:0];
        rd_a_addr = (state_reg == S_OIDX) ? k_reg[AW-1:0] : a_reg[AW-1:0];
        rd_b_addr = b_reg[AW-1:0];
        wr_addr   = k_reg[AW-1:0];
        m_user    = drop_reg;
        m_last    = (k_reg + W'(1)) == n_ext;
        take_b    = (b_reg < hi_reg) && ((a_reg >= mid_reg) || stat.less_ba);
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        src_next   = src_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.src_bank = src_reg;
        cmd.take_b   = take_b;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg < CW'(MAX_SEGMENTS)) begin
                        cmd.load_wr = 1'b1;
                        count_next  = count_reg + CW'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last) begin
                        width_next = W'(1);
                        src_next   = 1'b0;
                        state_next = S_PASS;
                    end
                end
            end
            // Start a pass, or go to output once one run covers the set.
            S_PASS: begin
                if (width_reg >= n_ext) begin
                    k_next     = '0;
                    state_next = S_OIDX;
                end else begin
                    lo_next    = '0;
                    state_next = S_RUN;
                end
            end
            // Set up the next pair of runs, or finish the pass.
            S_RUN: begin
                if (lo_reg >= n_ext) begin
                    width_next = width_reg << 1;
                    src_next   = ~src_reg;
                    state_next = S_PASS;
                end else begin
                    mid_next   = (lo_w < n_ext) ? lo_w : n_ext;
                    hi_next    = (lo_2w < n_ext) ? lo_2w : n_ext;
                    a_next     = lo_reg;
                    b_next     = (lo_w < n_ext) ? lo_w : n_ext;
                    k_next     = lo_reg;
                    state_next = S_RIDX;
                end
            end
            S_RIDX: begin
                cmd.idx_rd = 1'b1;
                state_next = S_RKEY;
            end
            S_RKEY: begin
                cmd.key_rd = 1'b1;
                state_next = S_CMP;
            end
            // Write one merged index; the left run wins ties.
            S_CMP: begin
                cmd.merge_wr = 1'b1;
                if (take_b) begin
                    b_next = b_reg + W'(1);
                end else begin
                    a_next = a_reg + W'(1);
                end
                k_next = k_reg + W'(1);
                if ((k_reg + W'(1)) == hi_reg) begin
                    lo_next    = hi_reg;
                    state_next = S_RUN;
                end else begin
                    state_next = S_RIDX;
                end
            end
            S_OIDX: begin
                cmd.idx_rd = 1'b1;
                state_next = S_OPAY;
            end
            S_OPAY: begin
                cmd.pay_rd = 1'b1;
                state_next = S_SEND;
            end
            // Hold the item until it is taken.
            S_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (m_last) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        k_next     = k_reg + W'(1);
                        state_next = S_OIDX;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    `LMMS_ASSERT(a_one_side, aclk, aresetn, !(s_ready && m_valid), "both channels active")
    `LMMS_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CW'(MAX_SEGMENTS),
                 "count beyond capacity")
    `LMMS_ASSERT_IMPL(a_merge_bounds, aclk, aresetn, state_reg == S_CMP,
                      (k_reg < hi_reg) && (a_reg <= mid_reg) && (b_reg <= hi_reg),
                      "merge pointers out of run")
    `LMMS_ASSERT_NEXT(a_run_clears, aclk, aresetn, m_valid && m_ready && m_last,
                      (count_reg == '0) && !drop_reg, "store not emptied after run")

endmodule

@@ rtl/line_midpoint_merge_sorter_core.sv @@
// Top level of the line midpoint merge sorter.
//
//  Channel  | Direction | Content
//  s_axis   | in        | tdata: one segment, tlast: last segment of the set
//  m_axis   | out       | tdata: sorted segment, tlast: last of run, tuser: overflowed
//
// Loading accepts one segment per cycle while the input is valid. After the last
// segment, each merge pass takes every segment through index read, key read, and
// compare and write, over ceil(log2 N) passes, with a setup state per run pair and
// per pass and a final one before output. Each result goes through index read,
// payload read and present, and is held in present while the output stalls.
// Reset is synchronous, active low, and empties the store; no input is taken
// while sorting or emitting, and a stalled output item holds its value.
module line_midpoint_merge_sorter_core
    import lmms_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, start_z, start_color, end_x, end_y, end_z, end_color
    input  logic [((6*COORD_BITS+COLOR_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_start_x, out_start_y, out_start_z, out_start_color,
    // out_end_x, out_end_y, out_end_z, out_end_color
    output logic [((6*COORD_BITS+COLOR_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // overflowed
    output logic                   m_axis_tuser
);

    localparam int PW = 6 * COORD_BITS + 2 * COLOR_BITS;
    localparam int DW = ((PW + 7) / 8) * 8;
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    lmms_cmd_t     cmd;
    lmms_stat_t    stat;
    logic [AW-1:0] load_addr, rd_a_addr, rd_b_addr, wr_addr;
    logic [PW-1:0] out_payload;

    lmms_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_axis_tvalid),
        .s_last(s_axis_tlast),
        .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_last(m_axis_tlast),
        .m_user(m_axis_tuser),
        .cmd(cmd),
        .stat(stat),
        .load_addr(load_addr),
        .rd_a_addr(rd_a_addr),
        .rd_b_addr(rd_b_addr),
        .wr_addr(wr_addr)
    );

    lmms_dp #(
        .COORD_BITS(COORD_BITS),
        .AW(AW),
        .PW(PW)
    ) u_dp (
        .aclk(aclk),
        .cmd(cmd),
        .stat(stat),
        .in_payload(s_axis_tdata[PW-1:0]),
        .load_addr(load_addr),
        .rd_a_addr(rd_a_addr),
        .rd_b_addr(rd_b_addr),
        .wr_addr(wr_addr),
        .out_payload(out_payload)
    );

    assign m_axis_tdata = DW'(out_payload);

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the line midpoint merge sorter core.
module tb
    import lmms_pkg::*;
();

    localparam int NSEG  = 64;
    localparam int CB    = 16;
    localparam int DW    = ((6*CB+COLOR_BITS+COLOR_BITS+7)/8)*8;

    // One segment as it travels on the streams.
    typedef struct packed {
        logic [31:0] end_color;
        logic [15:0] end_z;
        logic [15:0] end_y;
        logic [15:0] end_x;
        logic [31:0] start_color;
        logic [15:0] start_z;
        logic [15:0] start_y;
        logic [15:0] start_x;
    } segment_t;

    typedef struct packed {
        segment_t seg;
        logic     last;
    } seg_item_t;

    typedef struct packed {
        segment_t seg;
        logic     run_end;
        logic     overflowed;
    } sorted_item_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic          m_axis_tlast;
    logic          m_axis_tuser;

    line_midpoint_merge_sorter_core u_top (.*);

    always #2 aclk = ~aclk;

    seg_item_t    pending_segs[$];
    sorted_item_t expected_sorted[$];
    segment_t     held_segs[$];
    logic         held_dropped;
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         hold_off;

    // Ascending midpoint sums, x first then y; stable insertion keeps arrival order.
    function automatic logic seg_before(segment_t a, segment_t b);
        logic signed [16:0] ax, bx, ay, by;
        ax = $signed(a.start_x) + $signed(a.end_x);
        bx = $signed(b.start_x) + $signed(b.end_x);
        ay = $signed(a.start_y) + $signed(a.end_y);
        by = $signed(b.start_y) + $signed(b.end_y);
        if (ax != bx) return ax < bx;
        return ay < by;
    endfunction

    // Append one item to the queue of pending input items.
    task automatic enqueue_seg(seg_item_t it);
        pending_segs.insert(pending_segs.size(), it);
    endtask

    // Record each accepted segment and predict the sorted run at the last one.
    task automatic predict_sorted_run(seg_item_t it);
        segment_t sorted[$];
        sorted_item_t r;
        int pos;
        if (held_segs.size() < NSEG) held_segs.insert(held_segs.size(), it.seg);
        else held_dropped = 1'b1;
        if (!it.last) return;
        foreach (held_segs[i]) begin
            pos = sorted.size();
            while (pos > 0 && seg_before(held_segs[i], sorted[pos-1])) pos--;
            sorted.insert(pos, held_segs[i]);
        end
        foreach (sorted[i]) begin
            r.seg = sorted[i];
            r.run_end = (i == sorted.size() - 1);
            r.overflowed = held_dropped;
            expected_sorted.insert(expected_sorted.size(), r);
        end
        held_segs.delete();
        held_dropped = 1'b0;
    endtask

    // Sender: feed pending segments with random gaps.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) predict_sorted_run(
                seg_item_t'({s_axis_tdata[DW-1:0], s_axis_tlast}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_segs.size() > 0 && !hold_off &&
                    $urandom_range(99) >= send_idle_pct) begin
                    seg_item_t nx;
                    nx = pending_segs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nx.seg;
                    s_axis_tlast  <= nx.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        if (aresetn) begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                sorted_item_t got, want;
                got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (expected_sorted.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, got);
                    errors++;
                end else begin
                    want = expected_sorted.pop_front();
                    if (got.seg !== want.seg) begin
                        $display("%0t: segment expected %h actual %h", $time,
                                 want.seg, got.seg);
                        errors++;
                    end
                    if (got.run_end !== want.run_end) begin
                        $display("%0t: tlast expected %b actual %b", $time,
                                 want.run_end, got.run_end);
                        errors++;
                    end
                    if (got.overflowed !== want.overflowed) begin
                        $display("%0t: tuser expected %b actual %b", $time,
                                 want.overflowed, got.overflowed);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic segment_t rand_seg(int mode);
        segment_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom};
        // Narrow coordinates make equal midpoints likely.
        if (mode == 1) begin
            s.start_x = 16'($urandom_range(3)); s.end_x = 16'($urandom_range(3));
            s.start_y = 16'($urandom_range(3)); s.end_y = 16'($urandom_range(3));
        end
        return s;
    endfunction

    task automatic add_set(int n, int mode);
        seg_item_t it;
        for (int i = 0; i < n; i++) begin
            it.seg  = rand_seg(mode);
            it.last = (i == n - 1);
            enqueue_seg(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_segs.size() > 0 || s_axis_tvalid || expected_sorted.size() > 0)
            @(posedge aclk);
    endtask

    // Stimulus sequence.
    initial begin
        seg_item_t it;
        int n;
        errors = 0; held_dropped = 1'b0; hold_off = 1'b0;
        send_idle_pct = 33; recv_idle_pct = 57;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, single segment, ties, equal x with differing y.
        it.last = 1'b1;
        it.seg = {32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        enqueue_seg(it);
        it.last = 1'b0;
        it.seg = {32'h0, 16'h8000, 16'h8000, 16'h8000, 32'h0, 16'h8000, 16'h8000, 16'h8000};
        enqueue_seg(it);
        it.seg = {32'h1, 16'h0, 16'h0005, 16'h0001, 32'h2, 16'h0, 16'h0, 16'h0001};
        enqueue_seg(it);
        it.seg = {32'h3, 16'h0, 16'h0001, 16'h0002, 32'h4, 16'h0, 16'h0, 16'h0};
        enqueue_seg(it);
        it.seg = {32'h5, 16'h0, 16'h0001, 16'h0002, 32'h6, 16'h0, 16'h0, 16'h0};
        enqueue_seg(it);
        it.seg = {32'h7, 16'h1, 16'h7FFF, 16'h8000, 32'h8, 16'h1, 16'h8000, 16'h7FFF};
        it.last = 1'b1;
        enqueue_seg(it);
        add_set(8, 1);
        add_set(2, 0);

        // Pause until all results have arrived.
        wait_drained();
        hold_off = 1'b1;
        repeat (20) @(posedge aclk);
        hold_off = 1'b0;

        // Full store plus overflow, including an overflowing final segment.
        add_set(NSEG + 3, 1);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 57; recv_idle_pct = 33; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int k = 0; k < 6; k++) begin
                n = $urandom_range(1, 4);
                add_set(n, $urandom_range(1));
            end
            wait_drained();
        end
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_sorted.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ line_midpoint_merge_sorter_core.f @@
+incdir+rtl
rtl/lmms_pkg.sv
rtl/lmms_dp.sv
rtl/lmms_ctrl.sv
rtl/line_midpoint_merge_sorter_core.sv
tb/tb.sv
